// ===== hdl/lss_pkg.sv =====
package lss_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_SEARCH = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    localparam logic [1:0] MODE_LINEAR = 2'd0;
    localparam logic [1:0] MODE_SORTED = 2'd1;
    localparam logic [1:0] MODE_BINARY = 2'd2;

    localparam logic [2:0] REG_SEARCH_MODE = 3'd0;

    typedef logic [DATA_WIDTH-1:0] t_data;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic signed [CNT_W:0] t_sidx;

    typedef struct packed {
        logic load;
        logic scan;
        logic bin_rd;
        logic bin_cmp;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic stop;
        logic exhausted;
        logic bin_open;
        logic bin_eq;
    } t_stat;

    function automatic t_data to_store(logic [31:0] v);
        logic [63:0] z;
        z = {32'd0, v};
        return z[DATA_WIDTH-1:0];
    endfunction

    function automatic logic [31:0] widen(t_data x);
        logic [63:0] e;
        e = 64'($signed(x));
        return e[31:0];
    endfunction

    function automatic logic lt_signed(t_data a, t_data b);
        return $signed(a) < $signed(b);
    endfunction

    function automatic logic [5:0] pos_field(t_idx p);
        logic [63:0] z;
        z = 64'(p);
        return z[5:0];
    endfunction

    function automatic logic [6:0] cnt_field(t_cnt c);
        logic [63:0] z;
        z = 64'(c);
        return z[6:0];
    endfunction

endpackage

// ===== hdl/lss_item_if.sv =====
interface lss_item_if;
    import lss_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic signed [31:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

// ===== hdl/lss_res_if.sv =====
interface lss_res_if;
    import lss_pkg::*;

    logic               valid;
    logic               ready;
    logic               found;
    logic [5:0]         position;
    logic [6:0]         count;
    logic               full_drop;
    logic signed [31:0] largest;
    logic signed [31:0] smallest;
    logic signed [31:0] total;
    logic signed [31:0] product;

    modport source (output valid, output found, output position, output count,
                    output full_drop, output largest, output smallest, output total,
                    output product, input ready);
    modport sink   (input valid, input found, input position, input count,
                    input full_drop, input largest, input smallest, input total,
                    input product, output ready);
endinterface

// ===== hdl/lss_ctrl.sv =====
module lss_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [1:0]    i_kind,
    input  logic [1:0]    i_search_mode,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  lss_pkg::t_stat i_stat,
    output lss_pkg::t_cmd  o_cmd
);
    import lss_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_BRD  = 3'd3;
    localparam logic [2:0] S_BCMP = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_out_vld, n_out_vld;
    logic       slot_free;

    assign slot_free   = !r_out_vld || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_kind)
                        KIND_INSERT: n_state = S_MUL;
                        KIND_SEARCH: n_state = (i_search_mode == MODE_BINARY) ? S_BRD : S_SCAN;
                        default:     n_state = S_FIN;
                    endcase
                end
            end
            S_MUL: begin
                n_state = S_FIN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.hit || i_stat.stop || i_stat.exhausted) begin
                    n_state = S_FIN;
                end
            end
            S_BRD: begin
                if (i_stat.bin_open) begin
                    o_cmd.bin_rd = 1'b1;
                    n_state      = S_BCMP;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_BCMP: begin
                o_cmd.bin_cmp = 1'b1;
                n_state       = i_stat.bin_eq ? S_FIN : S_BRD;
            end
            S_FIN: begin
                if (slot_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (o_cmd.commit) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> o_out_valid)
        else $error("result not presented after commit");

    a_commit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (!r_out_vld || i_out_ready))
        else $error("commit overwrites a pending result");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state != S_IDLE))
        else $error("accepted item left no work");

endmodule

// ===== hdl/lss_datapath.sv =====
module lss_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lss_pkg::t_cmd      i_cmd,
    output lss_pkg::t_stat     o_stat,
    input  logic [1:0]         i_search_mode,
    input  logic [1:0]         i_kind,
    input  logic [31:0]        i_value,
    output logic               o_found,
    output logic [5:0]         o_position,
    output logic [6:0]         o_count,
    output logic               o_full_drop,
    output logic [31:0]        o_largest,
    output logic [31:0]        o_smallest,
    output logic [31:0]        o_total,
    output logic [31:0]        o_product
);
    import lss_pkg::*;

    t_data mem [CAPACITY];

    t_cnt  r_count, n_count;
    t_data r_max, n_max;
    t_data r_min, n_min;
    t_data r_sum, n_sum;
    t_data r_product, n_product;
    logic  r_rd_vld;

    logic [1:0] r_kind;
    t_data      r_key;
    t_data      r_mul;
    t_data      r_rdata;
    t_cnt       r_idx;
    t_idx       r_cmp_idx;
    t_sidx      r_lo;
    t_sidx      r_hi;
    t_idx       r_mid;
    logic       r_found;
    t_idx       r_pos;

    logic       r_o_found;
    logic [5:0] r_o_position;
    logic [6:0] r_o_count;
    logic       r_o_full_drop;
    logic [31:0] r_o_largest;
    logic [31:0] r_o_smallest;
    logic [31:0] r_o_total;
    logic [31:0] r_o_product;

    logic       key_eq;
    logic       scan_issue;
    logic       rd_en;
    t_idx       rd_addr;
    t_sidx      mid_sum;
    t_idx       mid;
    logic       is_ins;
    logic       is_full;
    logic       do_ins;
    logic       n_drop;

    assign key_eq     = (r_rdata == r_key);
    assign scan_issue = i_cmd.scan && (r_idx < r_count);
    assign mid_sum    = r_lo + r_hi;
    assign mid        = mid_sum[IDX_W:1];
    assign rd_en      = scan_issue || i_cmd.bin_rd;
    assign rd_addr    = i_cmd.bin_rd ? mid : r_idx[IDX_W-1:0];

    assign o_stat.hit       = r_rd_vld && key_eq;
    assign o_stat.stop      = r_rd_vld && (i_search_mode == MODE_SORTED) &&
                              lt_signed(r_key, r_rdata);
    assign o_stat.exhausted = !r_rd_vld && (r_idx >= r_count);
    assign o_stat.bin_open  = (r_lo <= r_hi);
    assign o_stat.bin_eq    = key_eq;

    assign is_ins  = (r_kind == KIND_INSERT);
    assign is_full = (r_count >= t_cnt'(CAPACITY));
    assign do_ins  = is_ins && !is_full;
    assign n_drop  = is_ins && is_full;

    always_comb begin
        n_count   = r_count;
        n_max     = r_max;
        n_min     = r_min;
        n_sum     = r_sum;
        n_product = r_product;
        if (do_ins) begin
            n_count   = r_count + t_cnt'(1);
            n_sum     = r_sum + r_key;
            n_product = r_mul;
            if (r_count == '0) begin
                n_max = r_key;
                n_min = r_key;
            end else begin
                if (lt_signed(r_max, r_key)) begin
                    n_max = r_key;
                end
                if (lt_signed(r_key, r_min)) begin
                    n_min = r_key;
                end
            end
        end else if (r_kind == KIND_CLEAR) begin
            n_count   = '0;
            n_max     = '0;
            n_min     = '0;
            n_sum     = '0;
            n_product = t_data'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
        if (i_cmd.commit && do_ins) begin
            mem[r_count[IDX_W-1:0]] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_max     <= '0;
            r_min     <= '0;
            r_sum     <= '0;
            r_product <= t_data'(1);
            r_rd_vld  <= 1'b0;
        end else begin
            r_rd_vld <= scan_issue;
            if (i_cmd.commit) begin
                r_count   <= n_count;
                r_max     <= n_max;
                r_min     <= n_min;
                r_sum     <= n_sum;
                r_product <= n_product;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mul <= r_product * r_key;
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_key   <= to_store(i_value);
            r_idx   <= '0;
            r_lo    <= '0;
            r_hi    <= t_sidx'(r_count) - t_sidx'(1);
            r_found <= 1'b0;
            r_pos   <= '0;
        end
        if (scan_issue) begin
            r_idx     <= r_idx + t_cnt'(1);
            r_cmp_idx <= r_idx[IDX_W-1:0];
        end
        if (i_cmd.scan && o_stat.hit) begin
            r_found <= 1'b1;
            r_pos   <= r_cmp_idx;
        end
        if (i_cmd.bin_rd) begin
            r_mid <= mid;
        end
        if (i_cmd.bin_cmp) begin
            if (key_eq) begin
                r_found <= 1'b1;
                r_pos   <= r_mid;
            end else if (lt_signed(r_rdata, r_key)) begin
                r_lo <= t_sidx'(r_mid) + t_sidx'(1);
            end else begin
                r_hi <= t_sidx'(r_mid) - t_sidx'(1);
            end
        end
        if (i_cmd.commit) begin
            r_o_found     <= (r_kind == KIND_SEARCH) && r_found;
            r_o_position  <= (r_kind == KIND_SEARCH) ? pos_field(r_pos) : 6'd0;
            r_o_count     <= cnt_field(n_count);
            r_o_full_drop <= n_drop;
            r_o_largest   <= (n_count != '0) ? widen(n_max) : 32'd0;
            r_o_smallest  <= (n_count != '0) ? widen(n_min) : 32'd0;
            r_o_total     <= widen(n_sum);
            r_o_product   <= widen(n_product);
        end
    end

    assign o_found     = r_o_found;
    assign o_position  = r_o_position;
    assign o_count     = r_o_count;
    assign o_full_drop = r_o_full_drop;
    assign o_largest   = r_o_largest;
    assign o_smallest  = r_o_smallest;
    assign o_total     = r_o_total;
    assign o_product   = r_o_product;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_cnt'(CAPACITY))
        else $error("fill count beyond capacity");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_issue |-> (t_cnt'(rd_addr) < r_count))
        else $error("scan reads beyond fill count");

    a_bin_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.bin_rd |-> (r_lo >= 0 && r_hi < t_sidx'(r_count)))
        else $error("binary probe outside held range");

endmodule

// ===== hdl/list_store_with_search_core.sv =====
// Insert passes through S_MUL before S_FIN; clear and unused kinds go straight to S_FIN.
// Linear search (modes 0, 1, 3): one store read per cycle, reading no further than the fill count.
// Binary search (mode 2): each probe is a store read (S_BRD) followed by a compare (S_BCMP).
// One item is in work at a time; the next transfer is taken once the result is registered.
// Reset (synchronous, active low) clears count, statistics, product to one and mode to 0;
// store contents stay undefined and are never read beyond the count.
module list_store_with_search_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lss_item_if.sink    i_in,
    lss_res_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lss_pkg::*;

    logic [1:0] r_search_mode;
    t_cmd       cmd;
    t_stat      stat;
    logic       in_ready;
    logic       out_valid;
    logic       reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = ({paddr[2], 2'b00} == REG_SEARCH_MODE);
    assign prdata  = reg_sel ? {30'd0, r_search_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_search_mode <= MODE_LINEAR;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_search_mode <= pwdata[1:0];
        end
    end

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

    lss_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in.valid),
        .o_in_ready    (in_ready),
        .i_kind        (i_in.kind),
        .i_search_mode (r_search_mode),
        .o_out_valid   (out_valid),
        .i_out_ready   (o_out.ready),
        .i_stat        (stat),
        .o_cmd         (cmd)
    );

    lss_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_search_mode (r_search_mode),
        .i_kind        (i_in.kind),
        .i_value       (i_in.value),
        .o_found       (o_out.found),
        .o_position    (o_out.position),
        .o_count       (o_out.count),
        .o_full_drop   (o_out.full_drop),
        .o_largest     (o_out.largest),
        .o_smallest    (o_out.smallest),
        .o_total       (o_out.total),
        .o_product     (o_out.product)
    );

endmodule

// ===== bench/tb_list_store_with_search_core.sv =====
module tb_list_store_with_search_core;
    timeunit 1ns;
    timeprecision 1ps;

    import lss_pkg::*;

    localparam logic [1:0] KIND_NONE  = 2'd3;
    localparam logic [1:0] MODE_ALIAS = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
    } t_list_op;

    typedef struct packed {
        logic        found;
        logic [5:0]  position;
        logic [6:0]  count;
        logic        full_drop;
        logic [31:0] largest;
        logic [31:0] smallest;
        logic [31:0] total;
        logic [31:0] product;
    } t_list_report;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    lss_item_if item_if();
    lss_res_if  res_if();

    list_store_with_search_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (item_if),
        .o_out   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predicted list contents and running statistics
    logic [31:0]  held [CAPACITY];
    int           held_count = 0;
    logic [31:0]  top_val    = '0;
    logic [31:0]  bottom_val = '0;
    logic [31:0]  sum_acc    = '0;
    logic [31:0]  prod_acc   = 32'd1;
    logic [1:0]   mode_reg   = MODE_LINEAR;

    t_list_op     op_queue [$];
    t_list_report report_queue [$];
    t_list_report want;
    t_list_op     cur_op;

    int  n_pushed   = 0;
    int  n_accepted = 0;
    int  n_reports  = 0;
    int  n_located  = 0;
    int  n_refused  = 0;
    int  modes_set  = 0;
    int  mismatches = 0;
    bit  took       = 1'b0;
    int  gap_left   = 0;
    int  burst_left = 0;
    int  seg_left   = 0;
    int  seg_kind   = 0;
    int  hold_left  = 0;
    bit  long_hold_req = 1'b0;
    logic rdy_next;

    function automatic t_list_report apply_list_op(logic [1:0] kind, logic [31:0] v);
        t_list_report r;
        int lo, hi, mid, hit;
        r = '0;
        hit = -1;
        case (kind)
            KIND_INSERT: begin
                if (held_count >= CAPACITY) begin
                    r.full_drop = 1'b1;
                end else begin
                    held[held_count] = v;
                    if (held_count == 0) begin
                        top_val = v;
                        bottom_val = v;
                    end else begin
                        if ($signed(top_val) < $signed(v)) top_val = v;
                        if ($signed(v) < $signed(bottom_val)) bottom_val = v;
                    end
                    sum_acc = sum_acc + v;
                    prod_acc = prod_acc * v;
                    held_count++;
                end
            end
            KIND_SEARCH: begin
                if (mode_reg == MODE_BINARY) begin
                    lo = 0;
                    hi = held_count - 1;
                    while (lo <= hi && hit < 0) begin
                        mid = (lo + hi) / 2;
                        if (held[mid] == v) hit = mid;
                        else if ($signed(held[mid]) < $signed(v)) lo = mid + 1;
                        else hi = mid - 1;
                    end
                end else begin
                    lo = 0;
                    while (lo < held_count && hit < 0) begin
                        if (held[lo] == v) hit = lo;
                        else if (mode_reg == MODE_SORTED && $signed(v) < $signed(held[lo]))
                            lo = held_count;
                        else lo++;
                    end
                end
                if (hit >= 0) begin
                    r.found = 1'b1;
                    r.position = hit[5:0];
                end
            end
            KIND_CLEAR: begin
                held_count = 0;
                top_val = '0;
                bottom_val = '0;
                sum_acc = '0;
                prod_acc = 32'd1;
            end
            default: ;
        endcase
        r.count    = held_count[6:0];
        r.largest  = (held_count != 0) ? top_val : '0;
        r.smallest = (held_count != 0) ? bottom_val : '0;
        r.total    = sum_acc;
        r.product  = prod_acc;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    task automatic push_op(logic [1:0] kind, logic [31:0] v);
        op_queue.push_back({kind, v});
        n_pushed++;
    endtask

    task automatic wait_for_quiet(int tail);
        while (n_accepted != n_pushed || report_queue.size() != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_search_mode(logic [1:0] m);
        logic [31:0] rd;
        wait_for_quiet(8);
        apb_access(1'b1, REG_SEARCH_MODE, {30'd0, m}, rd);
        mode_reg = m;
        apb_access(1'b0, REG_SEARCH_MODE, 32'd0, rd);
        check_field("search_mode", {30'd0, m}, rd);
        modes_set++;
    endtask

    task automatic queue_sequence();
        logic [31:0] vals [$];
        logic [31:0] key;
        longint      cur;
        int          shape, n, span;
        shape = $urandom_range(0, 99);
        if (shape < 70) begin
            // sorted run: mostly starts from an empty list
            if ($urandom_range(0, 4) != 0) push_op(KIND_CLEAR, $urandom);
            case ($urandom_range(0, 9))
                0:       n = CAPACITY + $urandom_range(0, 3);
                1:       n = 0;
                default: n = $urandom_range(1, 20);
            endcase
            case ($urandom_range(0, 3))
                0:       span = 3;
                1:       span = 1000;
                2:       span = 1 << 24;
                default: span = 32'h7fff_ffff;
            endcase
            case ($urandom_range(0, 2))
                0:       cur = -64'sd2147483648;
                1:       cur = longint'($signed($urandom));
                default: cur = longint'($urandom_range(0, 100)) - 50;
            endcase
            repeat (n) begin
                push_op(KIND_INSERT, cur[31:0]);
                vals.push_back(cur[31:0]);
                cur = cur + $urandom_range(0, span);
                if (cur > 64'sd2147483647) cur = 64'sd2147483647;
            end
            repeat ($urandom_range(1, 12)) begin
                key = (vals.size() != 0) ? vals[$urandom_range(0, vals.size() - 1)] : $urandom;
                case ($urandom_range(0, 9))
                    6: key = key + 32'd1;
                    7: key = key - 32'd1;
                    8: key = $urandom;
                    9: begin
                        case ($urandom_range(0, 3))
                            0:       key = 32'h8000_0000;
                            1:       key = 32'h7fff_ffff;
                            2:       key = 32'h0000_0000;
                            default: key = 32'hffff_ffff;
                        endcase
                    end
                    default: ;
                endcase
                push_op(KIND_SEARCH, key);
            end
        end else if (shape < 90) begin
            repeat ($urandom_range(1, 15)) begin
                key = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 7) - 3;
                push_op(2'($urandom_range(0, 3)), key);
            end
        end else begin
            // overfill an unsorted list
            push_op(KIND_CLEAR, $urandom);
            repeat (CAPACITY + $urandom_range(1, 4)) begin
                key = $urandom;
                push_op(KIND_INSERT, key);
                vals.push_back(key);
            end
            repeat (4) push_op(KIND_SEARCH, vals[$urandom_range(0, vals.size() - 1)]);
            push_op(KIND_NONE, $urandom);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // driver: bursts of transfers separated by random gaps
    always @(negedge i_clk) begin
        if (item_if.valid && !took) begin
            // hold the offered item
        end else begin
            took = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                item_if.valid <= 1'b0;
            end else if (op_queue.size() > 0) begin
                cur_op = op_queue.pop_front();
                item_if.valid <= 1'b1;
                item_if.kind  <= cur_op.kind;
                item_if.value <= cur_op.value;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                item_if.valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            rdy_next = 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = 400;
            rdy_next = 1'b0;
        end else begin
            if (seg_left == 0) begin
                seg_kind = $urandom_range(0, 3);
                seg_left = $urandom_range(5, 60);
            end
            seg_left--;
            case (seg_kind)
                0:       rdy_next = 1'b1;
                1:       rdy_next = ($urandom_range(0, 1) != 0);
                2:       rdy_next = ($urandom_range(0, 3) == 0);
                default: rdy_next = ($urandom_range(0, 7) != 0);
            endcase
        end
        res_if.ready <= rdy_next;
    end

    // monitor: predict on each input transfer, compare on each result transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (item_if.valid && item_if.ready) begin
                report_queue.push_back(apply_list_op(item_if.kind, item_if.value));
                took = 1'b1;
                n_accepted++;
            end
            if (res_if.valid && res_if.ready) begin
                n_reports++;
                if (report_queue.size() == 0) begin
                    $error("result transfer with no operation outstanding");
                    mismatches++;
                end else begin
                    want = report_queue.pop_front();
                    check_field("found",     32'(want.found),     32'(res_if.found));
                    check_field("position",  32'(want.position),  32'(res_if.position));
                    check_field("count",     32'(want.count),     32'(res_if.count));
                    check_field("full_drop", 32'(want.full_drop), 32'(res_if.full_drop));
                    check_field("largest",   want.largest,   res_if.largest);
                    check_field("smallest",  want.smallest,  res_if.smallest);
                    check_field("total",     want.total,     res_if.total);
                    check_field("product",   want.product,   res_if.product);
                    if (want.found) n_located++;
                    if (want.full_drop) n_refused++;
                end
            end
        end
    end

    initial begin
        logic [31:0] rd;
        logic [1:0]  m;
        int          phase;
        int          phase_end;
        int          rand_goal;
        item_if.valid = 1'b0;
        item_if.kind  = KIND_INSERT;
        item_if.value = '0;
        res_if.ready  = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        apb_access(1'b0, REG_SEARCH_MODE, 32'd0, rd);
        check_field("search_mode", {30'd0, MODE_LINEAR}, rd);
        set_search_mode(MODE_LINEAR);

        push_op(KIND_SEARCH, 32'd5);
        push_op(KIND_INSERT, 32'h8000_0000);
        push_op(KIND_INSERT, 32'h7fff_ffff);
        push_op(KIND_INSERT, 32'hffff_ffff);
        push_op(KIND_INSERT, 32'h0000_0000);
        push_op(KIND_INSERT, 32'h0000_0001);
        push_op(KIND_SEARCH, 32'h8000_0000);
        push_op(KIND_SEARCH, 32'h7fff_ffff);
        push_op(KIND_SEARCH, 32'h0000_0001);
        push_op(KIND_SEARCH, 32'h0000_0002);
        push_op(KIND_NONE,   32'hffff_ffff);
        push_op(KIND_CLEAR,  32'h0000_0000);
        push_op(KIND_SEARCH, 32'hffff_ffff);
        push_op(KIND_NONE,   32'h0000_0000);
        push_op(KIND_INSERT, 32'd5);
        push_op(KIND_INSERT, 32'hffff_fff9);
        push_op(KIND_SEARCH, 32'hffff_fff9);
        push_op(KIND_CLEAR,  32'hffff_ffff);

        set_search_mode(MODE_BINARY);
        push_op(KIND_INSERT, 32'hffff_fffd);
        push_op(KIND_INSERT, 32'h0000_0000);
        push_op(KIND_INSERT, 32'h0000_0004);
        push_op(KIND_SEARCH, 32'h0000_0004);
        push_op(KIND_SEARCH, 32'hffff_fffd);
        push_op(KIND_SEARCH, 32'h0000_0001);
        push_op(KIND_CLEAR,  32'h0000_0000);

        rand_goal = n_pushed + 1950;
        phase = 0;
        while (n_pushed < rand_goal) begin
            case (phase)
                0:       m = MODE_SORTED;
                1:       m = MODE_BINARY;
                2:       m = MODE_ALIAS;
                3:       m = MODE_LINEAR;
                default: m = 2'($urandom_range(0, 3));
            endcase
            set_search_mode(m);
            phase_end = n_pushed + $urandom_range(100, 200);
            while (n_pushed < phase_end) queue_sequence();
            if (phase == 0) long_hold_req = 1'b1;
            phase++;
        end
        wait_for_quiet(80);

        $display("Checked %0d list operations over %0d search-mode settings.", n_reports,
                 modes_set);
        $display("Searches that located their key: %0d; inserts refused at capacity: %0d.",
                 n_located, n_refused);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
